[sv/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants for the escape-count unit
// Fixed-point formats, port widths, register indexes, the sequencer states
// and the saturating helpers used by the datapath.
// ----------------------------------------------------------------------------
package mec_pkg;

  // Fixed-point format: signed, FRAC_BITS fraction bits, FRAC_BITS+6 bits in all
  localparam int FRAC_BITS = 30;
  localparam int FX_W      = FRAC_BITS + 6;
  localparam int MAG_W     = FX_W - 1;        // saturated product magnitude
  localparam int EXT_W     = FX_W + 2;        // headroom for sums before saturation
  localparam int HALF_W    = (FX_W + 1) / 2;  // multiplier operand slice
  localparam int ACC_W     = 2 * FX_W;        // full product

  // Image, count and total widths
  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int IDX_W     = 12;
  localparam int DEN_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = 16;
  localparam int TOT_W     = 40;

  // Coordinate divider: numerator 3*idx, quotient with FRAC_BITS fraction bits
  localparam int N_W       = IDX_W + 2;
  localparam int QUO_W     = N_W + FRAC_BITS;
  localparam int QCNT_W    = $clog2(QUO_W);

  // Ports
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = ((2 * IDX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CNT_W + TOT_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST    = DIM_W'(1000);
  localparam logic [DIM_W-1:0] HEIGHT_RST   = DIM_W'(1000);
  localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(1000);

  // Fixed-point constants
  localparam logic signed [EXT_W-1:0] FX_MAX_X =
      EXT_W'((64'sd1 <<< (FX_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] FX_MIN_X = -FX_MAX_X - EXT_W'(1);
  localparam logic signed [FX_W-1:0]  FX_MAX   = FX_MAX_X[FX_W-1:0];
  localparam logic signed [EXT_W-1:0] BASE_RE  = EXT_W'(-(64'sd2 <<< FRAC_BITS));
  localparam logic signed [EXT_W-1:0] BASE_IM  = EXT_W'(-(64'sd3 <<< (FRAC_BITS - 1)));
  localparam logic [FX_W-1:0]         FOUR     = FX_W'(64'd4 << FRAC_BITS);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_MAX_ITER
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  // Multiplier control: step to run, and whether the product carries a factor of two
  typedef struct packed {
    mul_op_t op;
    logic    dbl;
  } mul_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_RR_LO,
    ST_RR_HI,
    ST_II_LO,
    ST_II_HI,
    ST_XY_LO,
    ST_XY_HI,
    ST_UPDATE,
    ST_FINISH
  } mec_state_t;

  function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [EXT_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v > FX_MAX_X) begin
      r = FX_MAX;
    end else if (v < FX_MIN_X) begin
      r = FX_MIN_X[FX_W-1:0];
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [FX_W-1:0] fx_mag(input logic signed [FX_W-1:0] v);
    logic [FX_W-1:0] r;
    if (v[FX_W-1]) begin
      r = FX_W'(0) - FX_W'(v);
    end else begin
      r = FX_W'(v);
    end
    return r;
  endfunction

  // Clamp the dimension to [2, MAX_DIM] and return dimension - 1
  function automatic logic [DEN_W-1:0] dim_den(input logic [DIM_W-1:0] dim);
    logic [DEN_W-1:0] r;
    if (dim < DIM_W'(2)) begin
      r = DEN_W'(1);
    end else if (dim > DIM_W'(MAX_DIM)) begin
      r = DEN_W'(MAX_DIM - 1);
    end else begin
      r = DEN_W'(dim - DIM_W'(1));
    end
    return r;
  endfunction

  // base + quotient, saturated; an integer part of 64 or more pins at the max
  function automatic logic signed [FX_W-1:0] fx_coord(input logic [QUO_W-1:0] quo,
                                                      input logic signed [EXT_W-1:0] base);
    logic signed [EXT_W-1:0] sum;
    logic signed [FX_W-1:0]  r;
    sum = $signed(EXT_W'(quo[FX_W-1:0])) + base;
    if (quo[QUO_W-1:FX_W] != '0) begin
      r = FX_MAX;
    end else begin
      r = fx_sat(sum);
    end
    return r;
  endfunction

endpackage

[sv/mandelbrot_escape_count_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_unit: escape-time iteration count per pixel
// Maps a pixel onto the complex plane, iterates z = z*z + c and returns the
// escape count with a saturating per-frame running total.
// ----------------------------------------------------------------------------
// One pixel item is processed at a time; in_tready is high only while the unit
// is idle. An item runs escape_count + 1 iterations, or one fewer when the
// limit is reached without escape. The pixel-to-plane mapping uses a
// bit-serial divider for 44 quotient bits per coordinate, real then
// imaginary. Each iteration then runs the single 36x18 multiplier, which
// produces zr*zr, zi*zi and 2*zr*zi in two steps each, and an update state
// checks |z|^2 > 4 and updates z. The finished result sits in an output
// register, so the next item is accepted while it waits; a new result waits
// only if the previous one has still not been taken.
module mandelbrot_escape_count_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: pixel_row [11:0], pixel_column [23:12]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mec_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: frame_start [0]
  input  logic                            in_tuser,
  // out_tdata: escape_count [15:0], running_total [55:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mec_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [mec_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mec_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mec_pkg::*;

  mec_state_t state_r, state_nxt;

  logic [DIM_W-1:0]        width_r, height_r;
  logic [CNT_W-1:0]        limit_r;

  logic [IDX_W-1:0]        row_r, row_nxt;
  logic                    fs_r, fs_nxt;
  logic signed [FX_W-1:0]  cx_r, cx_nxt;
  logic signed [FX_W-1:0]  cy_r, cy_nxt;
  logic signed [FX_W-1:0]  zr_r, zr_nxt;
  logic signed [FX_W-1:0]  zi_r, zi_nxt;
  logic [MAG_W-1:0]        rr_r, rr_nxt;
  logic [MAG_W-1:0]        ii_r, ii_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    div_start;
  logic [N_W-1:0]          div_numer;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;

  mul_ctl_t                mul_ctl;
  logic [FX_W-1:0]         mul_a, mul_b;
  logic [MAG_W-1:0]        mul_mag;

  logic [IDX_W-1:0]        in_row, in_col;
  logic [FX_W-1:0]         zr_mag, zi_mag;
  logic                    escaped;
  logic signed [EXT_W-1:0] xy_signed;
  logic [CNT_W-1:0]        count_inc;
  logic [TOT_W-1:0]        total_base;
  logic [TOT_W:0]          total_sum;

  assign in_row = in_tdata[IDX_W-1:0];
  assign in_col = in_tdata[2*IDX_W-1:IDX_W];
  assign zr_mag = fx_mag(zr_r);
  assign zi_mag = fx_mag(zi_r);

  assign escaped   = ({1'b0, rr_r} + {1'b0, ii_r}) > FOUR;
  assign xy_signed = (zr_r[FX_W-1] ^ zi_r[FX_W-1]) ? -$signed(EXT_W'(mul_mag))
                                                   : $signed(EXT_W'(mul_mag));
  assign count_inc = count_r + CNT_W'(1);

  assign total_base = fs_r ? '0 : total_r;
  assign total_sum  = {1'b0, total_base} + (TOT_W+1)'(count_r);

  mec_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  mec_multiplier u_mul (
    .clk   (clk),
    .ctl   (mul_ctl),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .mag   (mul_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      limit_r     <= MAX_ITER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_WIDTH:    width_r  <= cfg_wdata[DIM_W-1:0];
          REG_HEIGHT:   height_r <= cfg_wdata[DIM_W-1:0];
          REG_MAX_ITER: limit_r  <= cfg_wdata[CNT_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    fs_r        <= fs_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    rr_r        <= rr_nxt;
    ii_r        <= ii_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    fs_nxt        = fs_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    count_nxt     = count_r;
    out_count_nxt = out_count_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_start     = 1'b0;
    div_numer     = (N_W'(in_col) << 1) + N_W'(in_col);
    div_den       = dim_den(width_r);
    mul_ctl.op    = MUL_IDLE;
    mul_ctl.dbl   = 1'b0;
    mul_a         = zr_mag;
    mul_b         = zr_mag;
    in_tready     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          div_start = 1'b1;
          row_nxt   = in_row;
          fs_nxt    = in_tuser;
          state_nxt = ST_MAP_X;
        end
      end
      ST_MAP_X: begin
        div_numer = (N_W'(row_r) << 1) + N_W'(row_r);
        div_den   = dim_den(height_r);
        if (div_done) begin
          cx_nxt    = fx_coord(div_quo, BASE_RE);
          div_start = 1'b1;
          state_nxt = ST_MAP_Y;
        end
      end
      ST_MAP_Y: begin
        if (div_done) begin
          cy_nxt    = fx_coord(div_quo, BASE_IM);
          zr_nxt    = '0;
          zi_nxt    = '0;
          count_nxt = '0;
          state_nxt = (limit_r == '0) ? ST_FINISH : ST_RR_LO;
        end
      end
      ST_RR_LO: begin
        mul_ctl.op = MUL_LO;
        state_nxt  = ST_RR_HI;
      end
      ST_RR_HI: begin
        mul_ctl.op = MUL_HI;
        state_nxt  = ST_II_LO;
      end
      ST_II_LO: begin
        rr_nxt     = mul_mag;
        mul_ctl.op = MUL_LO;
        mul_a      = zi_mag;
        mul_b      = zi_mag;
        state_nxt  = ST_II_HI;
      end
      ST_II_HI: begin
        mul_ctl.op = MUL_HI;
        mul_a      = zi_mag;
        mul_b      = zi_mag;
        state_nxt  = ST_XY_LO;
      end
      ST_XY_LO: begin
        ii_nxt     = mul_mag;
        mul_ctl.op = MUL_LO;
        mul_b      = zi_mag;
        state_nxt  = ST_XY_HI;
      end
      ST_XY_HI: begin
        mul_ctl.op = MUL_HI;
        mul_b      = zi_mag;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        mul_ctl.dbl = 1'b1;
        if (escaped) begin
          state_nxt = ST_FINISH;
        end else begin
          zr_nxt    = fx_sat($signed(EXT_W'(rr_r)) - $signed(EXT_W'(ii_r))
                             + EXT_W'(cx_r));
          zi_nxt    = fx_sat(xy_signed + EXT_W'(cy_r));
          count_nxt = count_inc;
          state_nxt = (count_inc == limit_r) ? ST_FINISH : ST_RR_LO;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          total_nxt     = total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({total_r, out_count_r});

  // The high multiply step always completes a low step issued the cycle before
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_ctl.op == MUL_HI) |-> ($past(mul_ctl.op) == MUL_LO))
    else $error("multiplier high step without preceding low step");

  // The running total moves only when a result is loaded
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FINISH) |=> $stable(total_r))
    else $error("running total changed outside result load");

  // Divider completions land only in the mapping states
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MAP_X || state_r == ST_MAP_Y))
    else $error("divider finished outside coordinate mapping");

endmodule

[sv/mec_divider.sv]
// ----------------------------------------------------------------------------
// mec_divider: bit-serial restoring divider
// Computes floor(numer * 2^FRAC_BITS / denom), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mec_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mec_pkg::N_W-1:0]      numer,
  input  logic [mec_pkg::DEN_W-1:0]    denom,
  output logic                         done,
  output logic [mec_pkg::QUO_W-1:0]    quotient
);
  import mec_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUO_W-1:0]  quo_r;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic              fits;

  // Shift in the next dividend bit; the quotient fills in behind it
  assign rem_sh   = {rem_r, quo_r[QUO_W-1]};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= QCNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - QCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= denom;
      quo_r <= {numer, {FRAC_BITS{1'b0}}};
    end else if (busy_r) begin
      rem_r <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[sv/mec_multiplier.sv]
// ----------------------------------------------------------------------------
// mec_multiplier: shared fixed-point magnitude multiplier
// One wide-by-half multiplier and accumulator; a full product takes a low
// and a high step. Output is the product rescaled and saturated.
// ----------------------------------------------------------------------------
module mec_multiplier (
  input  logic                      clk,
  input  mec_pkg::mul_ctl_t         ctl,
  input  logic [mec_pkg::FX_W-1:0]  a_mag,
  input  logic [mec_pkg::FX_W-1:0]  b_mag,
  output logic [mec_pkg::MAG_W-1:0] mag
);
  import mec_pkg::*;

  logic [ACC_W-1:0]       acc_r;
  logic [HALF_W-1:0]      b_part;
  logic [FX_W+HALF_W-1:0] prod;
  logic [ACC_W-1:0]       shifted;

  always_comb begin
    if (ctl.op == MUL_HI) begin
      b_part = HALF_W'(b_mag[FX_W-1:HALF_W]);
    end else begin
      b_part = b_mag[HALF_W-1:0];
    end
  end

  assign prod = a_mag * b_part;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      MUL_LO:   acc_r <= ACC_W'(prod);
      MUL_HI:   acc_r <= acc_r + (ACC_W'(prod) << HALF_W);
      default:  acc_r <= acc_r;
    endcase
  end

  // Drop the fraction; a doubled product drops one bit less
  assign shifted = ctl.dbl ? (acc_r >> (FRAC_BITS - 1)) : (acc_r >> FRAC_BITS);
  assign mag     = (shifted[ACC_W-1:MAG_W] != '0) ? '1 : shifted[MAG_W-1:0];

endmodule
